// File: src/spvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spvg_pkg
// Shared types and constants of the sprite and playfield video generator.
// ----------------------------------------------------------------------------
package spvg_pkg;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_READ  = 3'd2;
    localparam logic [2:0] FUNC_FIRE  = 3'd3;
    localparam logic [2:0] FUNC_CLRFR = 3'd4;

    localparam logic [5:0] A_VSYNC  = 6'h00;
    localparam logic [5:0] A_VBLANK = 6'h01;
    localparam logic [5:0] A_WSYNC  = 6'h02;
    localparam logic [5:0] A_RSYNC  = 6'h03;
    localparam logic [5:0] A_NUSIZ0 = 6'h04;
    localparam logic [5:0] A_NUSIZ1 = 6'h05;
    localparam logic [5:0] A_COLUP0 = 6'h06;
    localparam logic [5:0] A_COLUP1 = 6'h07;
    localparam logic [5:0] A_COLUPF = 6'h08;
    localparam logic [5:0] A_COLUBK = 6'h09;
    localparam logic [5:0] A_CTRLPF = 6'h0A;
    localparam logic [5:0] A_REFP0  = 6'h0B;
    localparam logic [5:0] A_REFP1  = 6'h0C;
    localparam logic [5:0] A_PF0    = 6'h0D;
    localparam logic [5:0] A_PF1    = 6'h0E;
    localparam logic [5:0] A_PF2    = 6'h0F;
    localparam logic [5:0] A_RESP0  = 6'h10;
    localparam logic [5:0] A_RESP1  = 6'h11;
    localparam logic [5:0] A_RESM0  = 6'h12;
    localparam logic [5:0] A_RESM1  = 6'h13;
    localparam logic [5:0] A_RESBL  = 6'h14;
    localparam logic [5:0] A_GRP0   = 6'h1B;
    localparam logic [5:0] A_GRP1   = 6'h1C;
    localparam logic [5:0] A_ENAM0  = 6'h1D;
    localparam logic [5:0] A_ENAM1  = 6'h1E;
    localparam logic [5:0] A_ENABL  = 6'h1F;
    localparam logic [5:0] A_HMP0   = 6'h20;
    localparam logic [5:0] A_HMP1   = 6'h21;
    localparam logic [5:0] A_HMM0   = 6'h22;
    localparam logic [5:0] A_HMM1   = 6'h23;
    localparam logic [5:0] A_HMBL   = 6'h24;
    localparam logic [5:0] A_VDELP0 = 6'h25;
    localparam logic [5:0] A_VDELP1 = 6'h26;
    localparam logic [5:0] A_VDELBL = 6'h27;
    localparam logic [5:0] A_RESMP0 = 6'h28;
    localparam logic [5:0] A_RESMP1 = 6'h29;
    localparam logic [5:0] A_HMOVE  = 6'h2A;
    localparam logic [5:0] A_HMCLR  = 6'h2B;
    localparam logic [5:0] A_CXCLR  = 6'h2C;

    localparam logic [3:0] R_INPT4 = 4'hC;
    localparam logic [3:0] R_INPT5 = 4'hD;

    localparam logic [7:0] SCREEN_W = 8'd160;
    localparam logic [7:0] HALF_W   = 8'd80;

    // Object and playfield state seen by the pixel path.
    typedef struct packed {
        logic [1:0][7:0] ppos;
        logic [1:0][7:0] mpos;
        logic [7:0]      bpos;
        logic [1:0][7:0] nusiz;
        logic [1:0][7:0] grp;
        logic [1:0][7:0] grp_d;
        logic [1:0]      refp;
        logic [1:0]      enam;
        logic            enabl;
        logic            enabl_d;
        logic [1:0]      vdelp;
        logic            vdelbl;
        logic [1:0]      resmp;
        logic [23:0]     pf;
        logic [7:0]      ctrlpf;
        logic [3:0][6:0] colu;
        logic            vblank;
    } spvg_obj_t;

    // (x + 160 - pos) style distance, both inputs below 256.
    function automatic logic [7:0] dist160(input logic [7:0] x, input logic [7:0] pos);
        logic [7:0] p;
        logic [8:0] s;
        begin
            p = (pos >= SCREEN_W) ? pos - SCREEN_W : pos;
            s = {1'b0, x} + {1'b0, SCREEN_W} - {1'b0, p};
            if (s >= {1'b0, SCREEN_W}) s = s - {1'b0, SCREEN_W};
            dist160 = s[7:0];
        end
    endfunction

    // Reduce a value below 320 modulo 160.
    function automatic logic [7:0] mod160(input logic [8:0] v);
        logic [8:0] r;
        begin
            r = (v >= {1'b0, SCREEN_W}) ? v - {1'b0, SCREEN_W} : v;
            mod160 = r[7:0];
        end
    endfunction

endpackage

// File: src/sprite_playfield_video_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_playfield_video_generator
// Video chip core: beam counters, register file and at most one pixel per tick item.
// ----------------------------------------------------------------------------
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle while the result is taken (m_tready high); the object
// decode and priority path between the state registers and the result register sets this figure.
// Reset: aresetn low clears every state register and the output valid flag.
module sprite_playfield_video_generator
    import spvg_pkg::*;
#(
    parameter int LINE_CLOCKS   = 228,
    parameter int HBLANK_CLOCKS = 68,
    parameter int VISIBLE_LINES = 192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: reg_addr[5:0], wr_data[13:6], fire_player[14], fire_pressed[15]
    input  logic [15:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fields from bit 0: pixel_valid[0], pixel_x[8:1], pixel_y[16:9], pixel_color[24:17],
    // rd_data[32:25], halted[33], frame_done[34]; zero fill above
    output logic [39:0] m_tdata
);

    localparam logic [7:0] LC  = 8'(LINE_CLOCKS);
    localparam logic [7:0] HB  = 8'(HBLANK_CLOCKS);
    localparam logic [7:0] VL  = 8'(VISIBLE_LINES);
    localparam logic [7:0] RSY = 8'(LINE_CLOCKS - 3);

    spvg_obj_t   obj_reg, obj_next;
    logic [3:0]  hm_reg [5];
    logic [3:0]  hm_next [5];
    logic [14:0] cx_reg, cx_next;
    logic [7:0]  col_reg, col_next, line_reg, line_next;
    logic        vsync_reg, vsync_next, wsync_reg, wsync_next;
    logic        hmb_reg, hmb_next, frame_reg, frame_next;
    logic [1:0]  fire_reg, fire_next;
    logic [39:0] out_reg, out_next;
    logic        ov_reg;

    logic [2:0]  func;
    logic [5:0]  addr;
    logic [7:0]  wd;
    logic        take;
    logic [7:0]  x;
    logic        vis;
    logic [14:0] hits;
    logic [6:0]  color;

    assign func     = s_tuser;
    assign addr     = s_tdata[5:0];
    assign wd       = s_tdata[13:6];
    assign s_tready = ~ov_reg | m_tready;
    assign take     = s_tvalid & s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
    assign x        = col_reg - HB;
    assign vis      = (col_reg >= HB) && (x < SCREEN_W) && (line_reg < VL);

    spvg_pixel u_pixel (.obj(obj_reg), .x(x), .hits(hits), .color(color));

    function automatic logic [7:0] moved(input logic [7:0] pos, input logic [3:0] n);
        logic [8:0] v;
        begin
            v = n[3] ? {1'b0, pos} + 9'(5'd16 - {1'b0, n})
                     : {1'b0, pos} + {1'b0, SCREEN_W} - {5'd0, n};
            moved = mod160(v);
        end
    endfunction

    logic       early;
    logic [7:0] resp, resm, rd, lum;
    logic [3:0] ra;
    logic [7:0] add;
    logic [8:0] l1;

    always_comb begin
        obj_next   = obj_reg;
        hm_next    = hm_reg;
        cx_next    = cx_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        vsync_next = vsync_reg;
        wsync_next = wsync_reg;
        hmb_next   = hmb_reg;
        frame_next = frame_reg;
        fire_next  = fire_reg;
        rd         = 8'd0;
        early      = col_reg < HB;
        resp       = early ? 8'd3 : mod160({1'b0, x} + 9'd5);
        resm       = early ? 8'd2 : mod160({1'b0, x} + 9'd4);
        ra         = addr[3:0];
        add        = 8'd3;
        l1         = {1'b0, line_reg} + 9'd1;
        lum        = 8'd0;
        case (func)
            FUNC_TICK: begin
                if (vis) cx_next = cx_reg | hits;
                if (col_reg + 8'd1 >= LC || col_reg == 8'hFF) begin
                    col_next   = 8'd0;
                    wsync_next = 1'b0;
                    hmb_next   = 1'b0;
                    line_next  = (l1 >= {1'b0, VL}) ? 8'd0 : l1[7:0];
                end else begin
                    col_next = col_reg + 8'd1;
                end
            end
            FUNC_WRITE: begin
                case (addr)
                    A_VSYNC: begin
                        if (vsync_reg && !wd[1]) begin line_next = 8'd0; frame_next = 1'b1; end
                        vsync_next = wd[1];
                    end
                    A_VBLANK: obj_next.vblank = wd[1];
                    A_WSYNC:  wsync_next = 1'b1;
                    A_RSYNC:  col_next = RSY;
                    A_NUSIZ0: obj_next.nusiz[0] = wd;
                    A_NUSIZ1: obj_next.nusiz[1] = wd;
                    A_COLUP0: obj_next.colu[0] = wd[7:1];
                    A_COLUP1: obj_next.colu[1] = wd[7:1];
                    A_COLUPF: obj_next.colu[2] = wd[7:1];
                    A_COLUBK: obj_next.colu[3] = wd[7:1];
                    A_CTRLPF: obj_next.ctrlpf = wd;
                    A_REFP0:  obj_next.refp[0] = wd[3];
                    A_REFP1:  obj_next.refp[1] = wd[3];
                    A_PF0:    obj_next.pf[7:0] = wd;
                    A_PF1:    obj_next.pf[15:8] = wd;
                    A_PF2:    obj_next.pf[23:16] = wd;
                    A_RESP0:  obj_next.ppos[0] = resp;
                    A_RESP1:  obj_next.ppos[1] = resp;
                    A_RESM0:  obj_next.mpos[0] = resm;
                    A_RESM1:  obj_next.mpos[1] = resm;
                    A_RESBL:  obj_next.bpos = resm;
                    A_GRP0: begin
                        obj_next.grp[0]   = wd;
                        obj_next.grp_d[1] = obj_reg.grp[1];
                    end
                    A_GRP1: begin
                        obj_next.grp[1]   = wd;
                        obj_next.grp_d[0] = obj_reg.grp[0];
                        obj_next.enabl_d  = obj_reg.enabl;
                    end
                    A_ENAM0:  obj_next.enam[0] = wd[1];
                    A_ENAM1:  obj_next.enam[1] = wd[1];
                    A_ENABL:  obj_next.enabl = wd[1];
                    A_HMP0:   hm_next[0] = wd[7:4];
                    A_HMP1:   hm_next[1] = wd[7:4];
                    A_HMM0:   hm_next[2] = wd[7:4];
                    A_HMM1:   hm_next[3] = wd[7:4];
                    A_HMBL:   hm_next[4] = wd[7:4];
                    A_VDELP0: obj_next.vdelp[0] = wd[0];
                    A_VDELP1: obj_next.vdelp[1] = wd[0];
                    A_VDELBL: obj_next.vdelbl = wd[0];
                    A_RESMP0, A_RESMP1: begin
                        // Releasing the lock snaps the missile to its player's center.
                        if (obj_reg.resmp[addr[0]] && !wd[1]) begin
                            if (obj_reg.nusiz[addr[0]][2:0] == 3'd5) add = 8'd6;
                            else if (obj_reg.nusiz[addr[0]][2:0] == 3'd7) add = 8'd10;
                            obj_next.mpos[addr[0]] =
                                mod160({1'b0, obj_reg.ppos[addr[0]]} + {1'b0, add});
                        end
                        obj_next.resmp[addr[0]] = wd[1];
                    end
                    A_HMOVE: begin
                        obj_next.ppos[0] = moved(obj_reg.ppos[0], hm_reg[0]);
                        obj_next.ppos[1] = moved(obj_reg.ppos[1], hm_reg[1]);
                        obj_next.mpos[0] = moved(obj_reg.mpos[0], hm_reg[2]);
                        obj_next.mpos[1] = moved(obj_reg.mpos[1], hm_reg[3]);
                        obj_next.bpos    = moved(obj_reg.bpos, hm_reg[4]);
                        if (early) hmb_next = 1'b1;
                    end
                    A_HMCLR: for (int i = 0; i < 5; i++) hm_next[i] = 4'd0;
                    A_CXCLR: cx_next = 15'd0;
                    default: ;
                endcase
            end
            FUNC_READ: begin
                case (ra)
                    4'd0: rd = {cx_reg[0],  cx_reg[1],  6'd0};
                    4'd1: rd = {cx_reg[2],  cx_reg[3],  6'd0};
                    4'd2: rd = {cx_reg[4],  cx_reg[5],  6'd0};
                    4'd3: rd = {cx_reg[6],  cx_reg[7],  6'd0};
                    4'd4: rd = {cx_reg[8],  cx_reg[9],  6'd0};
                    4'd5: rd = {cx_reg[10], cx_reg[11], 6'd0};
                    4'd6: rd = {cx_reg[12], 7'd0};
                    4'd7: rd = {cx_reg[13], cx_reg[14], 6'd0};
                    R_INPT4: rd = {~fire_reg[0], 7'd0};
                    R_INPT5: rd = {~fire_reg[1], 7'd0};
                    default: rd = 8'd0;
                endcase
            end
            FUNC_FIRE:  fire_next[s_tdata[14]] = s_tdata[15];
            FUNC_CLRFR: frame_next = 1'b0;
            default: ;
        endcase
        if (func == FUNC_TICK && vis)
            lum = (hmb_reg && x < 8'd8) ? 8'd0 : {color, 1'b0};
        out_next = {5'd0, frame_next, wsync_next, rd, lum,
                    (func == FUNC_TICK && vis) ? line_reg : 8'd0,
                    (func == FUNC_TICK && vis) ? x : 8'd0,
                    func == FUNC_TICK && vis};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_reg   <= '0;
            for (int i = 0; i < 5; i++) hm_reg[i] <= 4'd0;
            cx_reg    <= '0;
            col_reg   <= '0;
            line_reg  <= '0;
            vsync_reg <= 1'b0;
            wsync_reg <= 1'b0;
            hmb_reg   <= 1'b0;
            frame_reg <= 1'b0;
            fire_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            if (take) begin
                obj_reg   <= obj_next;
                hm_reg    <= hm_next;
                cx_reg    <= cx_next;
                col_reg   <= col_next;
                line_reg  <= line_next;
                vsync_reg <= vsync_next;
                wsync_reg <= wsync_next;
                hmb_reg   <= hmb_next;
                frame_reg <= frame_next;
                fire_reg  <= fire_next;
                out_reg   <= out_next;
                ov_reg    <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_col: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < LC || col_reg == RSY) else $error("column out of range");
    a_pix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[8:1] < SCREEN_W && !m_tdata[17])
        else $error("bad pixel");

endmodule

// File: src/spvg_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spvg_pixel
// Combinational object decode, collision hits and colour priority for one column.
// ----------------------------------------------------------------------------
module spvg_pixel
    import spvg_pkg::*;
(
    input  spvg_obj_t   obj,
    input  logic [7:0]  x,
    output logic [14:0] hits,
    output logic [6:0]  color
);

    logic [1:0] p_on, m_on;
    logic       bl_on, pf_on;

    function automatic logic player_bit(input logic [7:0] d, input logic [2:0] mode,
                                        input logic [7:0] g, input logic refl);
        logic [2:0] b;
        logic       hit;
        logic [7:0] r;
        begin
            hit = 1'b0;
            b   = 3'd0;
            case (mode)
                3'd5: begin hit = d < 8'd16; r = d >> 1; b = r[2:0]; end
                3'd7: begin hit = d < 8'd32; r = d >> 2; b = r[2:0]; end
                default: begin
                    if (d < 8'd8) begin hit = 1'b1; b = d[2:0]; end
                    else if ((mode == 3'd1 || mode == 3'd3) && d >= 8'd16 && d < 8'd24) begin
                        hit = 1'b1; r = d - 8'd16; b = r[2:0];
                    end else if ((mode == 3'd2 || mode == 3'd3 || mode == 3'd6)
                                 && d >= 8'd32 && d < 8'd40) begin
                        hit = 1'b1; r = d - 8'd32; b = r[2:0];
                    end else if ((mode == 3'd4 || mode == 3'd6) && d >= 8'd64 && d < 8'd72) begin
                        hit = 1'b1; r = d - 8'd64; b = r[2:0];
                    end
                end
            endcase
            player_bit = hit & g[refl ? b : 3'd7 - b];
        end
    endfunction

    function automatic logic missile_bit(input logic [7:0] d, input logic [2:0] mode,
                                         input logic [1:0] wsel);
        logic [7:0] w;
        logic       hit;
        begin
            w   = 8'd1 << wsel;
            hit = d < w;
            if ((mode == 3'd1 || mode == 3'd3) && d >= 8'd16 && (d - 8'd16) < w) hit = 1'b1;
            if ((mode == 3'd2 || mode == 3'd3 || mode == 3'd6) && d >= 8'd32
                && (d - 8'd32) < w) hit = 1'b1;
            if ((mode == 3'd4 || mode == 3'd6) && d >= 8'd64 && (d - 8'd64) < w) hit = 1'b1;
            missile_bit = hit;
        end
    endfunction

    logic [5:0] pfi;
    logic [7:0] bw;
    logic [6:0] pfc;
    logic       pri, score;

    always_comb begin
        for (int n = 0; n < 2; n++) begin
            p_on[n] = player_bit(dist160(x, obj.ppos[n]), obj.nusiz[n][2:0],
                                 obj.vdelp[n] ? obj.grp_d[n] : obj.grp[n], obj.refp[n]);
            m_on[n] = obj.enam[n] & ~obj.resmp[n]
                    & missile_bit(dist160(x, obj.mpos[n]), obj.nusiz[n][2:0],
                                  obj.nusiz[n][5:4]);
        end
        bw    = 8'd1 << obj.ctrlpf[5:4];
        bl_on = (obj.vdelbl ? obj.enabl_d : obj.enabl) && (dist160(x, obj.bpos) < bw);
        pfi = x[7:2];
        if (pfi >= 6'd20) pfi = obj.ctrlpf[0] ? 6'd39 - pfi : pfi - 6'd20;
        if (pfi < 6'd4)       pf_on = obj.pf[4 + pfi[1:0]];
        else if (pfi < 6'd12) pf_on = obj.pf[8 + (5'd7 - 5'(pfi - 6'd4))];
        else                  pf_on = obj.pf[16 + 5'(pfi - 6'd12)];

        hits = {m_on[0] & m_on[1], p_on[0] & p_on[1], bl_on & pf_on,
                m_on[1] & bl_on, m_on[1] & pf_on, m_on[0] & bl_on, m_on[0] & pf_on,
                p_on[1] & bl_on, p_on[1] & pf_on, p_on[0] & bl_on, p_on[0] & pf_on,
                m_on[1] & p_on[1], m_on[1] & p_on[0], m_on[0] & p_on[0], m_on[0] & p_on[1]};

        pri   = obj.ctrlpf[2];
        score = obj.ctrlpf[1] & ~pri;
        pfc   = score ? obj.colu[(x >= HALF_W) ? 1 : 0] : obj.colu[2];
        if (obj.vblank) color = 7'd0;
        else if (pri) begin
            if (pf_on | bl_on)          color = pfc;
            else if (p_on[0] | m_on[0]) color = obj.colu[0];
            else if (p_on[1] | m_on[1]) color = obj.colu[1];
            else                        color = obj.colu[3];
        end else begin
            if (p_on[0] | m_on[0])      color = obj.colu[0];
            else if (p_on[1] | m_on[1]) color = obj.colu[1];
            else if (pf_on | bl_on)     color = pfc;
            else                        color = obj.colu[3];
        end
    end

endmodule

// File: dv/tb_sprite_playfield_video_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_playfield_video_generator
// Self-checking bench for the video generator. Items of every kind are sent
// on the input stream, and a behavioral beam and object model in the bench
// predicts each result item. Results are compared in order, all fields at once.
// ----------------------------------------------------------------------------
module tb_sprite_playfield_video_generator;
    import spvg_pkg::*;

    localparam int LINE_CLK  = 228;
    localparam int HBLANK    = 68;
    localparam int VIS_LINES = 192;
    localparam int STALL_MAX = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    always #5 aclk = ~aclk;

    sprite_playfield_video_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // One result item as the bench expects it, listed from the highest bit down
    // so that it lines up with the packed result bus.
    typedef struct packed {
        logic       frame_done;
        logic       halted;
        logic [7:0] rd_data;
        logic [7:0] pix_color;
        logic [7:0] pix_y;
        logic [7:0] pix_x;
        logic       pix_valid;
    } video_result_t;

    video_result_t pending_results[$];
    int mismatches = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int quiet_cycles = 0;

    // Shadow copy of the chip state.
    logic [7:0]  sh_ppos [2];
    logic [7:0]  sh_mpos [2];
    logic [7:0]  sh_bpos;
    logic [3:0]  sh_hm [5];
    logic [7:0]  sh_nusiz [2];
    logic [7:0]  sh_grp [2];
    logic [7:0]  sh_grp_d [2];
    logic [1:0]  sh_refp, sh_enam, sh_vdelp, sh_resmp;
    logic        sh_enabl, sh_enabl_d, sh_vdelbl;
    logic [23:0] sh_pf;
    logic [7:0]  sh_ctrlpf;
    logic [7:0]  sh_colu [4];
    logic [14:0] sh_cx;
    int          sh_col, sh_line;
    logic        sh_vsync, sh_vblank, sh_wsync, sh_hmblank, sh_frame;
    logic [1:0]  sh_fire;

    // Copy layouts: how many copies, where they start, and the stretch factor.
    int copy_cnt [8] = '{1, 2, 2, 3, 2, 1, 3, 1};
    int copy_off [8][3] = '{'{0, 0, 0}, '{0, 16, 0}, '{0, 32, 0}, '{0, 16, 32},
                            '{0, 64, 0}, '{0, 0, 0}, '{0, 32, 64}, '{0, 0, 0}};
    int copy_scale [8] = '{1, 1, 1, 1, 1, 2, 1, 4};
    // Latch index feeding read bits 7 and 6; 15 means the bit reads zero.
    int rd_hi_bit [8] = '{0, 2, 4, 6, 8, 10, 12, 13};
    int rd_lo_bit [8] = '{1, 3, 5, 7, 9, 11, 15, 14};

    task automatic clear_shadow();
        for (int i = 0; i < 2; i++) begin
            sh_ppos[i] = 0; sh_mpos[i] = 0; sh_nusiz[i] = 0;
            sh_grp[i] = 0; sh_grp_d[i] = 0;
        end
        for (int i = 0; i < 5; i++) sh_hm[i] = 0;
        for (int i = 0; i < 4; i++) sh_colu[i] = 0;
        sh_bpos = 0; sh_refp = 0; sh_enam = 0; sh_vdelp = 0; sh_resmp = 0;
        sh_enabl = 0; sh_enabl_d = 0; sh_vdelbl = 0; sh_pf = 0; sh_ctrlpf = 0;
        sh_cx = 0; sh_col = 0; sh_line = 0; sh_vsync = 0; sh_vblank = 0;
        sh_wsync = 0; sh_hmblank = 0; sh_frame = 0; sh_fire = 0;
    endtask

    function automatic int wrap_dist(int x, int pos);
        return (x + 160 - (pos % 160)) % 160;
    endfunction

    function automatic bit playfield_at(int x);
        int i;
        i = x / 4;
        if (i >= 20) i = sh_ctrlpf[0] ? 39 - i : i - 20;
        if (i < 4) return sh_pf[4 + i];
        if (i < 12) return sh_pf[8 + 7 - (i - 4)];
        return sh_pf[16 + i - 12];
    endfunction

    function automatic bit player_at(int n, int x);
        int mode, d, sc, b;
        logic [7:0] g;
        mode = sh_nusiz[n][2:0];
        d = wrap_dist(x, sh_ppos[n]);
        g = sh_vdelp[n] ? sh_grp_d[n] : sh_grp[n];
        sc = copy_scale[mode];
        for (int i = 0; i < copy_cnt[mode]; i++) begin
            if (d >= copy_off[mode][i] && d - copy_off[mode][i] < 8 * sc) begin
                b = (d - copy_off[mode][i]) / sc;
                return g[sh_refp[n] ? b : 7 - b];
            end
        end
        return 0;
    endfunction

    function automatic bit missile_at(int n, int x);
        int mode, w, d;
        mode = sh_nusiz[n][2:0];
        w = 1 << sh_nusiz[n][5:4];
        d = wrap_dist(x, sh_mpos[n]);
        if (!sh_enam[n] || sh_resmp[n]) return 0;
        for (int i = 0; i < copy_cnt[mode]; i++)
            if (d >= copy_off[mode][i] && d - copy_off[mode][i] < w) return 1;
        return 0;
    endfunction

    // Colour of visible column x; latches collisions even in vertical blank.
    function automatic logic [7:0] pixel_colour(int x);
        bit p0, p1, m0, m1, bl, pf, pri, score;
        logic [14:0] hits;
        logic [7:0] pfc;
        p0 = player_at(0, x); p1 = player_at(1, x);
        m0 = missile_at(0, x); m1 = missile_at(1, x);
        bl = (sh_vdelbl ? sh_enabl_d : sh_enabl) &&
             wrap_dist(x, sh_bpos) < (1 << sh_ctrlpf[5:4]);
        pf = playfield_at(x);
        hits = {m0 & m1, p0 & p1, bl & pf, m1 & bl, m1 & pf, m0 & bl, m0 & pf,
                p1 & bl, p1 & pf, p0 & bl, p0 & pf, m1 & p1, m1 & p0, m0 & p0, m0 & p1};
        sh_cx = sh_cx | hits;
        if (sh_vblank) return 8'd0;
        pri = sh_ctrlpf[2];
        score = sh_ctrlpf[1] && !pri;
        pfc = score ? sh_colu[x >= 80 ? 1 : 0] : sh_colu[2];
        if (pri) begin
            if (pf || bl) return pfc;
            if (p0 || m0) return sh_colu[0];
            if (p1 || m1) return sh_colu[1];
        end else begin
            if (p0 || m0) return sh_colu[0];
            if (p1 || m1) return sh_colu[1];
            if (pf || bl) return pfc;
        end
        return sh_colu[3];
    endfunction

    function automatic logic [7:0] apply_motion(logic [7:0] pos, logic [3:0] nib);
        int v;
        v = nib[3] ? pos + (16 - nib) : pos + 160 - nib;
        return 8'(v % 160);
    endfunction

    task automatic register_write(logic [5:0] addr, logic [7:0] v);
        bit early;
        int xv, mode;
        logic [7:0] resp, resm;
        early = sh_col < HBLANK;
        xv = early ? 0 : sh_col - HBLANK;
        resp = early ? 8'd3 : 8'((xv + 5) % 160);
        resm = early ? 8'd2 : 8'((xv + 4) % 160);
        case (addr)
            A_VSYNC: begin
                if (sh_vsync && !v[1]) begin
                    sh_line = 0;
                    sh_frame = 1;
                end
                sh_vsync = v[1];
            end
            A_VBLANK: sh_vblank = v[1];
            A_WSYNC:  sh_wsync = 1;
            A_RSYNC:  sh_col = LINE_CLK - 3;
            A_NUSIZ0: sh_nusiz[0] = v;
            A_NUSIZ1: sh_nusiz[1] = v;
            A_COLUP0: sh_colu[0] = v & 8'hFE;
            A_COLUP1: sh_colu[1] = v & 8'hFE;
            A_COLUPF: sh_colu[2] = v & 8'hFE;
            A_COLUBK: sh_colu[3] = v & 8'hFE;
            A_CTRLPF: sh_ctrlpf = v;
            A_REFP0:  sh_refp[0] = v[3];
            A_REFP1:  sh_refp[1] = v[3];
            A_PF0:    sh_pf[7:0] = v;
            A_PF1:    sh_pf[15:8] = v;
            A_PF2:    sh_pf[23:16] = v;
            A_RESP0:  sh_ppos[0] = resp;
            A_RESP1:  sh_ppos[1] = resp;
            A_RESM0:  sh_mpos[0] = resm;
            A_RESM1:  sh_mpos[1] = resm;
            A_RESBL:  sh_bpos = resm;
            A_GRP0: begin
                sh_grp[0] = v;
                sh_grp_d[1] = sh_grp[1];
            end
            A_GRP1: begin
                sh_grp[1] = v;
                sh_grp_d[0] = sh_grp[0];
                sh_enabl_d = sh_enabl;
            end
            A_ENAM0:  sh_enam[0] = v[1];
            A_ENAM1:  sh_enam[1] = v[1];
            A_ENABL:  sh_enabl = v[1];
            A_HMP0:   sh_hm[0] = v[7:4];
            A_HMP1:   sh_hm[1] = v[7:4];
            A_HMM0:   sh_hm[2] = v[7:4];
            A_HMM1:   sh_hm[3] = v[7:4];
            A_HMBL:   sh_hm[4] = v[7:4];
            A_VDELP0: sh_vdelp[0] = v[0];
            A_VDELP1: sh_vdelp[1] = v[0];
            A_VDELBL: sh_vdelbl = v[0];
            A_RESMP0, A_RESMP1: begin
                // Releasing the lock parks the missile at the player's centre.
                int n;
                n = (addr == A_RESMP1);
                if (sh_resmp[n] && !v[1]) begin
                    mode = sh_nusiz[n][2:0];
                    sh_mpos[n] = 8'((sh_ppos[n] + (mode == 5 ? 6 : mode == 7 ? 10 : 3)) % 160);
                end
                sh_resmp[n] = v[1];
            end
            A_HMOVE: begin
                sh_ppos[0] = apply_motion(sh_ppos[0], sh_hm[0]);
                sh_ppos[1] = apply_motion(sh_ppos[1], sh_hm[1]);
                sh_mpos[0] = apply_motion(sh_mpos[0], sh_hm[2]);
                sh_mpos[1] = apply_motion(sh_mpos[1], sh_hm[3]);
                sh_bpos = apply_motion(sh_bpos, sh_hm[4]);
                if (early) sh_hmblank = 1;
            end
            A_HMCLR: for (int i = 0; i < 5; i++) sh_hm[i] = 0;
            A_CXCLR: sh_cx = 0;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] register_read(logic [5:0] addr);
        logic [3:0] a;
        logic [7:0] r;
        a = addr[3:0];
        r = 0;
        if (a < 8) begin
            r[7] = sh_cx[rd_hi_bit[a]];
            if (rd_lo_bit[a] < 15) r[6] = sh_cx[rd_lo_bit[a]];
        end else if (a == R_INPT4) begin
            r[7] = !sh_fire[0];
        end else if (a == R_INPT5) begin
            r[7] = !sh_fire[1];
        end
        return r;
    endfunction

    // Advances the shadow by one item and returns the result it causes.
    task automatic predict_video_item(logic [2:0] fn, logic [5:0] addr, logic [7:0] data,
                                      logic fp, logic fpr, output video_result_t res);
        res = '0;
        case (fn)
            FUNC_TICK: begin
                if (sh_col >= HBLANK && sh_col - HBLANK < 160 && sh_line < VIS_LINES) begin
                    res.pix_valid = 1;
                    res.pix_x = 8'(sh_col - HBLANK);
                    res.pix_y = 8'(sh_line);
                    res.pix_color = pixel_colour(sh_col - HBLANK);
                    // The first eight columns after an early HMOVE are blanked.
                    if (sh_hmblank && res.pix_x < 8) res.pix_color = 0;
                    res.pix_color[0] = 1'b0;
                end
                sh_col++;
                if (sh_col >= LINE_CLK) begin
                    sh_col = 0;
                    sh_wsync = 0;
                    sh_hmblank = 0;
                    sh_line = (sh_line + 1 >= VIS_LINES) ? 0 : sh_line + 1;
                end
            end
            FUNC_WRITE: register_write(addr, data);
            FUNC_READ:  res.rd_data = register_read(addr);
            FUNC_FIRE:  sh_fire[fp] = fpr;
            FUNC_CLRFR: sh_frame = 0;
            default: ;
        endcase
        res.halted = sh_wsync;
        res.frame_done = sh_frame;
    endtask

    // Sends one item, with random idle cycles ahead of it, and records its result.
    task automatic send_item(logic [2:0] fn, logic [5:0] addr = '0, logic [7:0] data = '0,
                             logic fp = 1'b0, logic fpr = 1'b0);
        video_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {fpr, fp, data, addr};
        do @(posedge aclk); while (!s_tready);
        predict_video_item(fn, addr, data, fp, fpr, res);
        pending_results.push_back(res);
    endtask

    task automatic write_reg(logic [5:0] addr, logic [7:0] data);
        send_item(FUNC_WRITE, addr, data);
    endtask

    task automatic run_ticks(int n);
        repeat (n) send_item(FUNC_TICK);
    endtask

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            video_result_t got, want;
            got = m_tdata[34:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected valid=%0d x=%0d y=%0d col=%h rd=%h hlt=%0d fr=%0d, got valid=%0d x=%0d y=%0d col=%h rd=%h hlt=%0d fr=%0d",
                                 want.pix_valid, want.pix_x, want.pix_y, want.pix_color,
                                 want.rd_data, want.halted, want.frame_done,
                                 got.pix_valid, got.pix_x, got.pix_y, got.pix_color,
                                 got.rd_data, got.halted, got.frame_done);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Most registers once with edge values, plus HMOVE early in the line.
    task automatic test_register_writes();
        write_reg(A_PF0, 8'hF0);
        write_reg(A_PF1, 8'hA5);
        write_reg(A_PF2, 8'hFF);
        write_reg(A_COLUP0, 8'hFF);
        write_reg(A_COLUP1, 8'h35);
        write_reg(A_COLUPF, 8'h80);
        write_reg(A_COLUBK, 8'h00);
        write_reg(A_CTRLPF, 8'h35);
        write_reg(A_GRP0, 8'hFF);
        write_reg(A_GRP1, 8'h81);
        write_reg(A_ENAM0, 8'h02);
        write_reg(A_ENABL, 8'h02);
        write_reg(A_HMP0, 8'h80);
        write_reg(A_HMBL, 8'h70);
        write_reg(A_HMOVE, 8'h00);
        write_reg(6'h3F, 8'hFF);
        run_ticks(90);
        write_reg(A_RESP0, 8'h00);
        write_reg(A_RESBL, 8'h00);
        write_reg(A_VBLANK, 8'h02);
        run_ticks(4);
        write_reg(A_VBLANK, 8'h00);
        write_reg(A_WSYNC, 8'h00);
        write_reg(A_RSYNC, 8'h00);
        run_ticks(80);
    endtask

    // Collision reads on every address, fire buttons, frame flag, odd codes.
    task automatic test_reads_fire_sync();
        for (int a = 0; a < 16; a++) send_item(FUNC_READ, a[5:0]);
        send_item(FUNC_FIRE, 6'd0, 8'd0, 1'b0, 1'b1);
        send_item(FUNC_FIRE, 6'd0, 8'd0, 1'b1, 1'b1);
        send_item(FUNC_READ, {2'b11, R_INPT4});
        send_item(FUNC_READ, {2'b00, R_INPT5});
        write_reg(A_VSYNC, 8'h02);
        write_reg(A_VSYNC, 8'h00);
        send_item(FUNC_CLRFR);
        for (int f = 5; f < 8; f++) send_item(f[2:0], 6'h3F, 8'hFF);
        write_reg(A_CXCLR, 8'h00);
        write_reg(A_HMCLR, 8'h00);
    endtask

    // Random item mix: mostly ticks so the beam sweeps real lines.
    task automatic test_random_frames(int n);
        int k;
        logic [5:0] addr;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 62) begin
                send_item(FUNC_TICK, 6'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (k < 86) begin
                addr = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(6'h2C));
                // Keep vertical blank and sync rare so most pixels show colour.
                if (addr == A_VSYNC || addr == A_VBLANK || addr == A_RSYNC)
                    addr = ($urandom_range(3) == 0) ? addr : A_GRP0;
                write_reg(addr, 8'($urandom));
            end else if (k < 93) begin
                send_item(FUNC_READ, 6'($urandom), 8'($urandom));
            end else if (k < 96) begin
                send_item(FUNC_FIRE, 6'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (k < 98) begin
                send_item(FUNC_CLRFR, 6'($urandom), 8'($urandom));
            end else begin
                send_item(3'($urandom_range(7, 5)), 6'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        clear_shadow();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        snd_idle_pct = 34;
        rcv_idle_pct = 84;
        test_register_writes();
        test_reads_fire_sync();
        test_random_frames(350);
        snd_idle_pct = 84;
        rcv_idle_pct = 34;
        test_random_frames(350);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_frames(330);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
